[design/aes_pkg.sv]
`default_nettype none
package aes_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ENC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  key_index;
    logic [31:0] key_word;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_INIT,
    ST_ROUND,
    ST_OUT
  } state_t;

  localparam logic [7:0] REDUCE_POLY = 8'h1b;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], 1'b0};
    if (v[7]) begin
      r = r ^ REDUCE_POLY;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/aes_ram.sv]
`default_nettype none
module aes_ram #(
  parameter int Width = 32,
  parameter int Depth = 176
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[design/aes_round.sv]
`default_nettype none
// One cipher round on a 128-bit state; byte 4c+r is state_i[127-8*(4c+r) -: 8].
module aes_round (
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] rkey_i,
  input  wire logic         inverse_i,
  input  wire logic         last_i,
  output logic      [127:0] state_o
);

  logic [7:0] s   [16];
  logic [7:0] t   [16];
  logic [7:0] u   [16];
  logic [7:0] v   [16];
  logic [7:0] k   [16];
  logic [7:0] x4, x8, b0, b1, b2, b3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
      k[i] = rkey_i[127-8*i -: 8];
    end
    // Forward: shift, substitute. Inverse: inverse shift, inverse substitute.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse_i) begin
          t[4*((c+r)%4)+r] = aes_pkg::INV_SBOX[s[4*c+r]];
        end else begin
          t[4*c+r] = aes_pkg::FWD_SBOX[s[4*((c+r)%4)+r]];
        end
      end
    end
    // Forward mixes before the key, inverse adds the key first.
    for (int i = 0; i < 16; i++) begin
      u[i] = inverse_i ? (t[i] ^ k[i]) : t[i];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        b0 = u[4*c+r];
        b1 = u[4*c+(r+1)%4];
        b2 = u[4*c+(r+2)%4];
        b3 = u[4*c+(r+3)%4];
        if (inverse_i) begin
          // 14,11,13,9 coefficients.
          x4 = aes_pkg::xtime(aes_pkg::xtime(b0)) ^ aes_pkg::xtime(aes_pkg::xtime(b2));
          x8 = aes_pkg::xtime(aes_pkg::xtime(aes_pkg::xtime(b0 ^ b1 ^ b2 ^ b3)));
          v[4*c+r] = x8 ^ x4 ^ aes_pkg::xtime(b0) ^ aes_pkg::xtime(b1)
                   ^ b1 ^ b2 ^ b3;
        end else begin
          x4 = 8'h00;
          x8 = 8'h00;
          v[4*c+r] = aes_pkg::xtime(b0) ^ aes_pkg::xtime(b1) ^ b1 ^ b2 ^ b3;
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (last_i) begin
        state_o[127-8*i -: 8] = t[i] ^ k[i];
      end else if (inverse_i) begin
        state_o[127-8*i -: 8] = v[i];
      end else begin
        state_o[127-8*i -: 8] = v[i] ^ k[i];
      end
    end
  end

endmodule
`default_nettype wire

[design/aes_block_cipher_enc_dec.sv]
`default_nettype none
// Channel  | Ports                          | Payload
// input    | in_valid, in_stall, in_data    | aes_pkg::in_item_t
// result   | out_valid, out_stall, out_data | aes_pkg::out_item_t
//
// A load transaction writes one key word if its index is below the key word
// count. An encrypt or decrypt transaction passes through these states in
// order: idle, which accepts it and reads the first round key row; init, for
// the initial key addition; the round state for each round, each fed by a
// 128-bit read of the round key memory issued in the state before; and out,
// which moves the block into the output register. The result sits in the output
// register until taken; the next input is accepted while it waits, and a
// finished block holds in the output state while that register is full and stalled.
// Reset is synchronous and active low and clears only control state; key
// memory contents are undefined until loaded.
module aes_block_cipher_enc_dec #(
  parameter int ROUND_COUNT = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire aes_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output aes_pkg::out_item_t      out_data
);

  localparam int KeyWords = 4 * (ROUND_COUNT + 1);
  localparam int RowBits  = $clog2(ROUND_COUNT + 1);

  aes_pkg::state_t state_r, state_nxt;
  logic [RowBits-1:0] rnd_r, rnd_nxt;
  logic [RowBits-1:0] step_r, step_nxt;
  logic               inv_r, inv_nxt;
  logic [127:0]       blk_r, blk_nxt;
  logic               out_valid_r, out_valid_nxt;
  aes_pkg::out_item_t out_data_r;

  logic               accept;
  logic               key_wr;
  logic               out_load;
  logic [RowBits-1:0] rd_row;
  logic [127:0]       rkey;
  logic [127:0]       round_out;
  logic               last_round;

  assign in_stall  = (state_r != aes_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The finished block moves out once the output register is empty or being taken.
  assign out_load = (state_r == aes_pkg::ST_OUT) && (!out_valid_r || !out_stall);

  assign key_wr = accept && (in_data.op == aes_pkg::OP_LOAD)
                  && ({26'd0, in_data.key_index} < KeyWords);

  // Four column memories, one row per round key; column select is the low
  // two bits of the key index.
  for (genvar c = 0; c < 4; c++) begin : g_col
    aes_ram #(.Width(32), .Depth(ROUND_COUNT + 1)) u_ram (
      .clk     (clk),
      .wr_en   (key_wr && (in_data.key_index[1:0] == 2'(c))),
      .wr_addr (in_data.key_index[RowBits+1:2]),
      .wr_data (in_data.key_word),
      .rd_addr (rd_row),
      .rd_data (rkey[127-32*c -: 32])
    );
  end

  // Round row read this cycle is used next cycle.
  always_comb begin
    if (state_r == aes_pkg::ST_IDLE) begin
      rd_row = (in_data.op == aes_pkg::OP_DEC) ? RowBits'(ROUND_COUNT) : '0;
    end else begin
      rd_row = rnd_nxt;
    end
  end

  assign last_round = (step_r == RowBits'(ROUND_COUNT));

  aes_round u_round (
    .state_i   (blk_r),
    .rkey_i    (rkey),
    .inverse_i (inv_r),
    .last_i    (last_round),
    .state_o   (round_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aes_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      rnd_r       <= '0;
      step_r      <= '0;
      inv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rnd_r       <= rnd_nxt;
      step_r      <= step_nxt;
      inv_r       <= inv_nxt;
    end
    blk_r <= blk_nxt;
    if (out_load) begin
      out_data_r <= blk_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    step_nxt      = step_r;
    inv_nxt       = inv_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      aes_pkg::ST_IDLE: begin
        if (accept && (in_data.op == aes_pkg::OP_ENC || in_data.op == aes_pkg::OP_DEC)) begin
          inv_nxt   = (in_data.op == aes_pkg::OP_DEC);
          rnd_nxt   = rd_row;
          blk_nxt   = {in_data.block_hi, in_data.block_lo};
          state_nxt = aes_pkg::ST_INIT;
        end
      end
      aes_pkg::ST_INIT: begin
        // Key row for the initial addition arrives now; prepare round 1's row.
        blk_nxt   = blk_r ^ rkey;
        rnd_nxt   = inv_r ? rnd_r - 1'b1 : rnd_r + 1'b1;
        step_nxt  = RowBits'(1);
        state_nxt = aes_pkg::ST_ROUND;
      end
      aes_pkg::ST_ROUND: begin
        blk_nxt  = round_out;
        step_nxt = step_r + 1'b1;
        rnd_nxt  = inv_r ? rnd_r - 1'b1 : rnd_r + 1'b1;
        if (last_round) begin
          state_nxt = aes_pkg::ST_OUT;
        end
      end
      aes_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = aes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aes_pkg::ST_IDLE;
      end
    endcase
  end

  // The read address in a busy state tracks the row register of the next
  // cycle; rd_row therefore equals rnd_nxt, and the memory output in each
  // busy state holds row rnd_r.

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != aes_pkg::ST_IDLE) |-> !accept) else $error("accept while busy");
  a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid) else $error("missing result");
  a_init_to_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aes_pkg::ST_INIT) |=> (state_r == aes_pkg::ST_ROUND))
    else $error("bad init step");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
